### rtl/core/ipdc64_pkg.sv
// ============================================================================
// ipdc64_pkg
// Shared types and constants of the 64-wide DC / V / H intra predictor.
// ============================================================================
package ipdc64_pkg;

    localparam logic [1:0] REQ_LOAD_ABOVE = 2'd0;
    localparam logic [1:0] REQ_LOAD_LEFT  = 2'd1;
    localparam logic [1:0] REQ_READ       = 2'd2;

    localparam logic [2:0] MODE_DC   = 3'd0;
    localparam logic [2:0] MODE_TOP  = 3'd1;
    localparam logic [2:0] MODE_LEFT = 3'd2;
    localparam logic [2:0] MODE_128  = 3'd3;
    localparam logic [2:0] MODE_VERT = 3'd4;
    localparam logic [2:0] MODE_HORZ = 3'd5;

    localparam logic REG_PRED_MODE   = 1'b0;
    localparam logic REG_HEIGHT_CODE = 1'b1;

    localparam logic [1:0] HSEL_16 = 2'd0;
    localparam logic [1:0] HSEL_32 = 2'd1;
    localparam logic [1:0] HSEL_64 = 2'd2;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_DIV3 = 2'd1;
    localparam logic [1:0] SH_DIV5 = 2'd2;

    localparam logic [15:0] RND_DIV128 = 16'd64;
    localparam logic [15:0] RND_DIV96  = 16'd48;
    localparam logic [15:0] RND_DIV80  = 16'd40;
    localparam logic [15:0] RND_DIV64  = 16'd32;

    localparam logic [11:0] RECIP_3   = 12'd683;
    localparam int          RECIP_SH3 = 11;
    localparam logic [11:0] RECIP_5   = 12'd3277;
    localparam int          RECIP_SH5 = 14;

    localparam logic [7:0] DC_FLAT = 8'd128;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_MUL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_upd;
        logic sum_en;
        logic mul_en;
        logic out_en;
    } ipdc64_cmd_t;

endpackage

### rtl/core/intra_pred_dc_v_h_64wide_unit.sv
// ============================================================================
// intra_pred_dc_v_h_64wide_unit
// Intra predictor (DC, DC top, DC left, DC 128, vertical, horizontal) for
// blocks 64 pixels wide and 16, 32 or 64 rows high.
// ============================================================================
// A command is taken when start is high and busy is low. Load commands read
// the old reference byte from the single-port memory when taken, then update
// the running sum and write the new byte. Read commands step through sum,
// reciprocal multiply and pixel select, and their result shows on pixels and
// row_out_of_range for the one cycle that done is high, from a register behind
// the pixel select; a new command may be taken in that same cycle. The
// receiver cannot stall results. Unused request code three is taken in the
// idle state and gives no result. Reference stores read as zero after reset.
module intra_pred_dc_v_h_64wide_unit #(
    parameter int MAX_ROWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [5:0]  position,
    input  logic [2:0]  column_group,
    input  logic [7:0]  ref_value,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    output logic        done,
    output logic [63:0] pixels,
    output logic        row_out_of_range
);
    import ipdc64_pkg::*;

    ipdc64_cmd_t cmd;

    ipdc64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .cmd      (cmd)
    );

    ipdc64_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .req_type         (req_type),
        .position         (position),
        .column_group     (column_group),
        .ref_value        (ref_value),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixels           (pixels),
        .row_out_of_range (row_out_of_range),
        .done             (done)
    );

endmodule

### rtl/core/ipdc64_ctrl.sv
// ============================================================================
// ipdc64_ctrl
// Sequencer: accepts commands and steps the datapath through load and read.
// ============================================================================
module ipdc64_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [1:0]              req_type,
    output logic                    busy,
    output ipdc64_pkg::ipdc64_cmd_t cmd
);
    import ipdc64_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type) inside
                        REQ_LOAD_ABOVE, REQ_LOAD_LEFT: state_next = S_LOAD;
                        REQ_READ:                      state_next = S_SUM;
                        default:                       state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:  state_next = S_IDLE;
            S_SUM:   state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = 1'b1;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            S_LOAD:  cmd.load_upd = 1'b1;
            S_SUM:   cmd.sum_en   = 1'b1;
            S_MUL:   cmd.mul_en   = 1'b1;
            S_OUT:   cmd.out_en   = 1'b1;
            default: busy         = 1'b1;
        endcase
    end

endmodule

### rtl/core/ipdc64_dp.sv
// ============================================================================
// ipdc64_dp
// Datapath: reference memories, running sums, DC divide and pixel select.
// ============================================================================
module ipdc64_dp #(
    parameter int MAX_ROWS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipdc64_pkg::ipdc64_cmd_t cmd,
    input  logic [1:0]              req_type,
    input  logic [5:0]              position,
    input  logic [2:0]              column_group,
    input  logic [7:0]              ref_value,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [2:0]              cfg_data,
    output logic [63:0]             pixels,
    output logic                    row_out_of_range,
    output logic                    done
);
    import ipdc64_pkg::*;

    localparam logic [1:0] HCAP = (MAX_ROWS >= 64) ? HSEL_64 :
                                  (MAX_ROWS >= 32) ? HSEL_32 : HSEL_16;

    logic [63:0] above_mem [8];
    logic [7:0]  left_mem  [64];

    logic [2:0]  pred_mode_reg;
    logic [1:0]  height_code_reg;
    logic [63:0] above_valid_reg;
    logic [63:0] left_valid_reg;
    logic [13:0] above_total_reg;
    logic [11:0] left_first_reg;
    logic [11:0] left_second_reg;
    logic [12:0] left_upper_reg;
    logic [1:0]  type_reg;
    logic [5:0]  pos_reg;
    logic [2:0]  grp_reg;
    logic [7:0]  val_reg;
    logic [63:0] above_rd_reg;
    logic [7:0]  left_rd_reg;
    logic [10:0] y_reg;
    logic [11:0] k_reg;
    logic [1:0]  shsel_reg;
    logic [22:0] prod_reg;
    logic [63:0] pixels_reg;
    logic        oor_reg;
    logic        done_reg;

    logic [2:0]  above_raddr;
    logic        above_we;
    logic        left_we;
    logic [7:0]  old_above;
    logic [7:0]  old_left;
    logic [1:0]  hsel_raw;
    logic [1:0]  hsel;
    logic [13:0] left_sum;
    logic [14:0] dc_sum;
    logic [15:0] num;
    logic [10:0] y_next;
    logic [11:0] k_next;
    logic [1:0]  shsel_next;
    logic [7:0]  dc_byte;
    logic [63:0] above_vis;
    logic [7:0]  row_mask;
    logic [63:0] pix;
    logic        oor;

    assign above_raddr = (req_type == REQ_READ) ? column_group : position[5:3];
    assign above_we    = cmd.load_upd && (type_reg == REQ_LOAD_ABOVE);
    assign left_we     = cmd.load_upd && (type_reg == REQ_LOAD_LEFT);
    assign old_above   = above_valid_reg[pos_reg] ?
                         above_rd_reg[{pos_reg[2:0], 3'b000} +: 8] : 8'd0;
    assign old_left    = left_valid_reg[pos_reg] ? left_rd_reg : 8'd0;

    always_ff @(posedge clk)
    begin
        if (above_we)
        begin
            above_mem[pos_reg[5:3]][{pos_reg[2:0], 3'b000} +: 8] <= val_reg;
        end
        if (left_we)
        begin
            left_mem[pos_reg] <= val_reg;
        end
        if (cmd.accept)
        begin
            above_rd_reg <= above_mem[above_raddr];
            left_rd_reg  <= left_mem[position];
            type_reg     <= req_type;
            pos_reg      <= position;
            grp_reg      <= column_group;
            val_reg      <= ref_value;
        end
        if (cmd.sum_en)
        begin
            y_reg     <= y_next;
            k_reg     <= k_next;
            shsel_reg <= shsel_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= 23'(y_reg) * 23'(k_reg);
        end
        if (cmd.out_en)
        begin
            pixels_reg <= oor ? 64'd0 : pix;
            oor_reg    <= oor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_mode_reg   <= MODE_DC;
            height_code_reg <= HSEL_64;
            above_valid_reg <= '0;
            left_valid_reg  <= '0;
            above_total_reg <= '0;
            left_first_reg  <= '0;
            left_second_reg <= '0;
            left_upper_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.out_en;
            if (cfg_we && (cfg_index == REG_PRED_MODE))
            begin
                pred_mode_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_HEIGHT_CODE))
            begin
                height_code_reg <= cfg_data[1:0];
            end
            if (above_we)
            begin
                above_valid_reg[pos_reg] <= 1'b1;
                above_total_reg <= above_total_reg + 14'(val_reg) - 14'(old_above);
            end
            if (left_we)
            begin
                left_valid_reg[pos_reg] <= 1'b1;
                case (pos_reg[5:4])
                    2'd0:    left_first_reg  <= left_first_reg + 12'(val_reg)
                                                - 12'(old_left);
                    2'd1:    left_second_reg <= left_second_reg + 12'(val_reg)
                                                - 12'(old_left);
                    default: left_upper_reg  <= left_upper_reg + 13'(val_reg)
                                                - 13'(old_left);
                endcase
            end
        end
    end

    // Clamp height code three to sixty-four rows, then cap at the row limit.
    assign hsel_raw = (height_code_reg > HSEL_64) ? HSEL_64 : height_code_reg;
    assign hsel     = (hsel_raw > HCAP) ? HCAP : hsel_raw;

    assign left_sum = 14'(left_first_reg)
                    + ((hsel != HSEL_16) ? 14'(left_second_reg) : 14'd0)
                    + ((hsel == HSEL_64) ? 14'(left_upper_reg) : 14'd0);
    assign dc_sum   = 15'(above_total_reg) + 15'(left_sum);

    always_comb
    begin
        num        = '0;
        y_next     = '0;
        k_next     = 12'd1;
        shsel_next = SH_NONE;
        unique case (pred_mode_reg)
            MODE_DC:
            begin
                unique case (hsel)
                    HSEL_64:
                    begin
                        num    = 16'(dc_sum) + RND_DIV128;
                        y_next = 11'(num >> 7);
                    end
                    HSEL_32:
                    begin
                        num        = 16'(dc_sum) + RND_DIV96;
                        y_next     = 11'(num >> 5);
                        k_next     = RECIP_3;
                        shsel_next = SH_DIV3;
                    end
                    default:
                    begin
                        num        = 16'(dc_sum) + RND_DIV80;
                        y_next     = 11'(num >> 4);
                        k_next     = RECIP_5;
                        shsel_next = SH_DIV5;
                    end
                endcase
            end
            MODE_TOP:
            begin
                num    = 16'(above_total_reg) + RND_DIV64;
                y_next = 11'(num >> 6);
            end
            MODE_LEFT:
            begin
                num    = 16'(left_sum) + (16'd8 << hsel);
                y_next = 11'(num >> (3'd4 + 3'(hsel)));
            end
            default:
            begin
                num = '0;
            end
        endcase
    end

    always_comb
    begin
        case (shsel_reg)
            SH_DIV3: dc_byte = prod_reg[RECIP_SH3 +: 8];
            SH_DIV5: dc_byte = prod_reg[RECIP_SH5 +: 8];
            default: dc_byte = prod_reg[7:0];
        endcase
    end

    assign row_mask = above_valid_reg[{grp_reg, 3'b000} +: 8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            above_vis[i*8 +: 8] = row_mask[i] ? above_rd_reg[i*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        case (hsel)
            HSEL_16: oor = (pos_reg[5:4] != 2'd0);
            HSEL_32: oor = pos_reg[5];
            default: oor = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (pred_mode_reg)
            MODE_DC, MODE_TOP, MODE_LEFT: pix = {8{dc_byte}};
            MODE_VERT:                    pix = above_vis;
            MODE_HORZ:                    pix = {8{old_left}};
            default:                      pix = {8{DC_FLAT}};
        endcase
    end

    assign pixels           = pixels_reg;
    assign row_out_of_range = oor_reg;
    assign done             = done_reg;

endmodule

### rtl/core/ipdc64_checker.sv
// ============================================================================
// ipdc64_checker
// Port-level timing checks of the intra predictor, bound to the top level.
// ============================================================================
module ipdc64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic        done,
    input logic [63:0] pixels,
    input logic        row_out_of_range
);
    import ipdc64_pkg::*;

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_READ) |-> ##4 done)
        else $error("read transfer did not complete in four cycles");

    a_load_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((req_type == REQ_LOAD_ABOVE) || (req_type == REQ_LOAD_LEFT))
        |=> busy ##1 !busy)
        else $error("load did not take two cycles");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && row_out_of_range |-> (pixels == 64'd0))
        else $error("out-of-range row returned nonzero pixels");

endmodule

bind intra_pred_dc_v_h_64wide_unit ipdc64_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .done             (done),
    .pixels           (pixels),
    .row_out_of_range (row_out_of_range)
);

### sim/tb_intra_pred_dc_v_h_64wide_unit.sv
// ----------------------------------------------------------------------------
// tb_intra_pred_dc_v_h_64wide_unit
// Self-checking bench for the 64-wide DC / V / H intra predictor. A queue of
// load and read commands feeds a bursty driver. Accepted commands update a
// local copy of the reference stores and running sums. Each read predicts the
// 8-pixel chunk, and a monitor compares every done strobe against it.
// ----------------------------------------------------------------------------
module tb_intra_pred_dc_v_h_64wide_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ipdc64_pkg::*;

    localparam int         CLK_HALF     = 5;
    localparam int         CYCLE_LIMIT  = 100000;
    localparam int         SETTLE       = 6;
    localparam int         ITEM_TARGET  = 850;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] pos;
        logic [2:0] grp;
        logic [7:0] val;
    } request_t;

    typedef struct packed {
        logic [63:0] pixels;
        logic        oor;
    } chunk_t;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic [1:0]  req_type         = '0;
    logic [5:0]  position         = '0;
    logic [2:0]  column_group     = '0;
    logic [7:0]  ref_value        = '0;
    logic        cfg_we           = 1'b0;
    logic        cfg_index        = 1'b0;
    logic [2:0]  cfg_data         = '0;
    logic        busy;
    logic        done;
    logic [63:0] pixels;
    logic        row_out_of_range;

    request_t    pending_q[$];
    chunk_t      chunk_q[$];
    request_t    next_req;

    logic [7:0]  above_ref[64];
    logic [7:0]  left_ref[64];
    int          above_total;
    int          left_first16;
    int          left_second16;
    int          left_upper32;
    logic [2:0]  mode_sel;
    logic [1:0]  height_sel;

    int          burst_left  = 1;
    int          gap_left    = 0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          n_loads     = 0;
    int          n_reads     = 0;
    int          n_oor       = 0;
    int          n_checked   = 0;
    int          n_phases    = 0;
    int          n_pushed    = 0;

    intra_pred_dc_v_h_64wide_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .position         (position),
        .column_group     (column_group),
        .ref_value        (ref_value),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .pixels           (pixels),
        .row_out_of_range (row_out_of_range)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int row_count(logic [1:0] code);
        case (code)
            HSEL_16: return 16;
            HSEL_32: return 32;
            default: return 64;
        endcase
    endfunction

    function automatic chunk_t predict_chunk(logic [5:0] row, logic [2:0] grp);
        chunk_t     c;
        int         rows;
        int         lsum;
        int         dc;
        logic [7:0] dc8;
        rows     = row_count(height_sel);
        c.oor    = 1'b0;
        c.pixels = '0;
        if (row >= rows)
        begin
            c.oor = 1'b1;
            return c;
        end
        lsum = left_first16;
        if (rows >= 32)
            lsum += left_second16;
        if (rows >= 64)
            lsum += left_upper32;
        case (mode_sel)
            MODE_DC:
            begin
                if (rows == 64)
                    dc = (above_total + lsum + 64) >> 7;
                else if (rows == 32)
                    dc = (above_total + lsum + 48) / 96;
                else
                    dc = (above_total + lsum + 40) / 80;
            end
            MODE_TOP:  dc = (above_total + 32) >> 6;
            MODE_LEFT: dc = (lsum + rows / 2) / rows;
            MODE_VERT: dc = 0;
            MODE_HORZ: dc = left_ref[row];
            default:   dc = 128;
        endcase
        dc8 = dc[7:0];
        if (mode_sel == MODE_VERT)
        begin
            for (int i = 0; i < 8; i++)
                c.pixels[8 * i +: 8] = above_ref[grp * 8 + i];
        end
        else
        begin
            c.pixels = {8{dc8}};
        end
        return c;
    endfunction

    function automatic void apply_request(request_t r);
        chunk_t c;
        case (r.kind)
            REQ_LOAD_ABOVE:
            begin
                above_total = above_total + r.val - above_ref[r.pos];
                above_ref[r.pos] = r.val;
                n_loads++;
            end
            REQ_LOAD_LEFT:
            begin
                if (r.pos < 16)
                    left_first16 = left_first16 + r.val - left_ref[r.pos];
                else if (r.pos < 32)
                    left_second16 = left_second16 + r.val - left_ref[r.pos];
                else
                    left_upper32 = left_upper32 + r.val - left_ref[r.pos];
                left_ref[r.pos] = r.val;
                n_loads++;
            end
            REQ_READ:
            begin
                c = predict_chunk(r.pos, r.grp);
                chunk_q.push_back(c);
                n_reads++;
                if (c.oor)
                    n_oor++;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_req(logic [1:0] kind, logic [5:0] pos, logic [2:0] grp,
                                     logic [7:0] val);
        request_t r;
        r.kind = kind;
        r.pos  = pos;
        r.grp  = grp;
        r.val  = val;
        pending_q.push_back(r);
        n_pushed++;
    endfunction

    function automatic void push_random(int rows);
        int         pick;
        logic [5:0] row;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            row = 6'($urandom_range(0, rows - 1));
            for (int g = 0; g < 8; g++)
                push_req(REQ_READ, row, 3'(g), random_byte());
        end
        else if (pick < 40)
        begin
            push_req(REQ_LOAD_ABOVE, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                     random_byte());
        end
        else if (pick < 68)
        begin
            push_req(REQ_LOAD_LEFT, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                     random_byte());
        end
        else if (pick < 97)
        begin
            if ($urandom_range(0, 9) == 0)
                row = 6'($urandom_range(0, 63));
            else
                row = 6'($urandom_range(0, rows - 1));
            push_req(REQ_READ, row, 3'($urandom_range(0, 7)), random_byte());
        end
        else
        begin
            push_req(REQ_UNUSED, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                     random_byte());
        end
    endfunction

    task automatic write_reg(logic idx, logic [2:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_PRED_MODE)
            mode_sel = val;
        else
            height_sel = val[1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (!(pending_q.size() == 0 && !start && !busy && chunk_q.size() == 0));
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_config(logic [2:0] mode, logic [2:0] hval);
        write_reg(REG_PRED_MODE, mode);
        write_reg(REG_HEIGHT_CODE, hval);
        @(negedge clk);
        n_phases++;
    endtask

    // drive commands in bursts; update the prediction state on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            req_type     <= '0;
            position     <= '0;
            column_group <= '0;
            ref_value    <= '0;
        end
        else
        begin
            if (start && !busy)
                apply_request({req_type, position, column_group, ref_value});
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    next_req = pending_q.pop_front();
                    start        <= 1'b1;
                    req_type     <= next_req.kind;
                    position     <= next_req.pos;
                    column_group <= next_req.grp;
                    ref_value    <= next_req.val;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (chunk_q.size() == 0)
            begin
                $error("unexpected result: pixels %h row_out_of_range %b",
                       pixels, row_out_of_range);
                error_count++;
            end
            else
            begin
                chunk_t want;
                want = chunk_q.pop_front();
                n_checked++;
                if (pixels !== want.pixels)
                begin
                    $error("pixels: expected %h actual %h", want.pixels, pixels);
                    error_count++;
                end
                if (row_out_of_range !== want.oor)
                begin
                    $error("row_out_of_range: expected %b actual %b",
                           want.oor, row_out_of_range);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int rows;
        for (int i = 0; i < 64; i++)
        begin
            above_ref[i] = '0;
            left_ref[i]  = '0;
        end
        above_total   = 0;
        left_first16  = 0;
        left_second16 = 0;
        left_upper32  = 0;
        mode_sel      = MODE_DC;
        height_sel    = HSEL_64;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: zero stores, then edge loads and reads
        push_req(REQ_READ, 6'd0, 3'd0, 8'h00);
        push_req(REQ_LOAD_ABOVE, 6'd0, 3'd0, 8'hFF);
        push_req(REQ_LOAD_ABOVE, 6'd63, 3'd7, 8'hFF);
        push_req(REQ_LOAD_LEFT, 6'd0, 3'd0, 8'hFF);
        push_req(REQ_LOAD_LEFT, 6'd15, 3'd0, 8'hFF);
        push_req(REQ_LOAD_LEFT, 6'd16, 3'd0, 8'hFF);
        push_req(REQ_LOAD_LEFT, 6'd31, 3'd0, 8'hFF);
        push_req(REQ_LOAD_LEFT, 6'd32, 3'd0, 8'hFF);
        push_req(REQ_LOAD_LEFT, 6'd63, 3'd0, 8'hFF);
        push_req(REQ_UNUSED, 6'd5, 3'd3, 8'hAA);
        push_req(REQ_READ, 6'd63, 3'd7, 8'h00);
        n_phases++;
        wait_idle();

        // every mode, every height code, last valid row and first row past the height where there is one
        for (int m = 0; m < 8; m++)
        begin
            set_config(3'(m), 3'(m % 4));
            rows = row_count(height_sel);
            push_req(REQ_READ, 6'(rows - 1), 3'd7, 8'h00);
            push_req(REQ_READ, (rows < 64) ? 6'(rows) : 6'd0, 3'd0, 8'hFF);
            wait_idle();
        end

        while (n_pushed < ITEM_TARGET)
        begin
            set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            rows = row_count(height_sel);
            repeat ($urandom_range(40, 90))
                push_random(rows);
            wait_idle();
        end

        $display("covered %0d loads and %0d reads (%0d past the block height) over %0d settings",
                 n_loads, n_reads, n_oor, n_phases);
        $display("compared %0d predicted chunks in %0d cycles", n_checked, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
